>>> sv/ial_pkg.sv
// Shared types and constants for the indexed array list block.
// Used by ial_ram, ial_seq and indexed_array_list; depends on nothing else.
package ial_pkg;

    // Built depth of the entry store, the widths that follow from it, and the field widths.
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;
    localparam int MW    = 3;
    localparam int IW    = 6;
    localparam int SW    = 2;

    // Request operation codes.
    localparam logic [MW-1:0] MODE_APPEND = 3'd0;
    localparam logic [MW-1:0] MODE_INSERT = 3'd1;
    localparam logic [MW-1:0] MODE_EDIT   = 3'd2;
    localparam logic [MW-1:0] MODE_DELETE = 3'd3;
    localparam logic [MW-1:0] MODE_READ   = 3'd4;
    localparam logic [MW-1:0] MODE_FIND   = 3'd5;

    // Result status codes.
    localparam logic [SW-1:0] ST_OK       = 2'd0;
    localparam logic [SW-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [SW-1:0] ST_BADINDEX = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_FIND,
        S_READ,
        S_RESULT
    } t_state;

    // One request as held by the sequencer.
    typedef struct packed {
        logic [MW-1:0]        mode;
        logic signed [DW-1:0] value;
        logic [IW-1:0]        index;
    } t_item;

    // Memory access issued by the sequencer for one cycle.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;

    // One result; the last member sits in the lowest bits.
    typedef struct packed {
        logic                 is_full;
        logic                 is_empty;
        logic [CW-1:0]        item_count;
        logic                 found;
        logic signed [DW-1:0] read_value;
        logic [SW-1:0]        status;
    } t_result;

endpackage

>>> sv/ial_ram.sv
// Entry store of the indexed array list: one write port and one read port.
// Read data is registered, so it appears in the cycle after the read. Uses ial_pkg.
module ial_ram (
    input  logic                      i_clk,
    input  ial_pkg::t_ram_req         i_req,
    output logic [ial_pkg::DW-1:0]    o_rdata
);

    logic [ial_pkg::DW-1:0] r_mem [ial_pkg::DEPTH];
    logic [ial_pkg::DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ial_seq.sv
// Request sequencer of the indexed array list: bounds checks, the fill count,
// and the read-then-write walks that shift or search the entry store.
// Uses ial_pkg; drives one ial_ram through a t_ram_req struct.
module ial_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  ial_pkg::t_item           i_item,
    output logic                     o_item_ready,
    input  logic [ial_pkg::CW-1:0]   i_cap,
    input  logic                     i_res_ready,
    output logic                     o_res_valid,
    output ial_pkg::t_result         o_res,
    output ial_pkg::t_ram_req        o_ram_req,
    input  logic [ial_pkg::DW-1:0]   i_ram_rdata
);

    ial_pkg::t_state            r_state, n_state;
    ial_pkg::t_item             r_item, n_item;
    logic [ial_pkg::CW-1:0]     r_count, n_count;
    logic [ial_pkg::CW-1:0]     r_ptr, n_ptr;
    logic [ial_pkg::SW-1:0]     r_status, n_status;
    logic [ial_pkg::DW-1:0]     r_rd, n_rd;
    logic                       r_found, n_found;

    logic [ial_pkg::CW-1:0]     w_eff_cap;
    logic                       w_full;
    logic [ial_pkg::CW-1:0]     w_idx;

    // Effective capacity saturates at the built depth.
    assign w_eff_cap = (i_cap > ial_pkg::CW'(ial_pkg::DEPTH)) ?
                       ial_pkg::CW'(ial_pkg::DEPTH) : i_cap;
    assign w_full    = (r_count >= w_eff_cap);
    assign w_idx     = ial_pkg::CW'(r_item.index);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ial_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Request payload and working registers.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_found  <= n_found;
    end

    // Next state, memory accesses and result fields.
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_status     = r_status;
        n_rd         = r_rd;
        n_found      = r_found;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_ram_req    = '0;

        unique case (r_state)
            ial_pkg::S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_item   = i_item;
                    n_status = ial_pkg::ST_OK;
                    n_rd     = '0;
                    n_found  = 1'b0;
                    n_state  = ial_pkg::S_START;
                end
            end

            ial_pkg::S_START: begin
                n_state = ial_pkg::S_RESULT;
                unique case (r_item.mode)
                    ial_pkg::MODE_APPEND: begin
                        if (w_full) begin
                            n_status = ial_pkg::ST_OVERFLOW;
                        end else begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_count[ial_pkg::AW-1:0];
                            o_ram_req.wdata = r_item.value;
                            n_count         = r_count + 1'b1;
                        end
                    end
                    ial_pkg::MODE_INSERT: begin
                        if (w_full) begin
                            n_status = ial_pkg::ST_OVERFLOW;
                        end else if (w_idx > r_count) begin
                            n_status = ial_pkg::ST_BADINDEX;
                        end else if (w_idx == r_count) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_item.index;
                            o_ram_req.wdata = r_item.value;
                            n_count         = r_count + 1'b1;
                        end else begin
                            // Walk down from the top, moving each entry up one place.
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = ial_pkg::AW'(r_count - 1'b1);
                            n_ptr           = r_count;
                            n_state         = ial_pkg::S_INS_SHIFT;
                        end
                    end
                    ial_pkg::MODE_EDIT: begin
                        if (w_idx >= r_count) begin
                            n_status = ial_pkg::ST_BADINDEX;
                        end else begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_item.index;
                            o_ram_req.wdata = r_item.value;
                        end
                    end
                    ial_pkg::MODE_DELETE: begin
                        if (w_idx >= r_count) begin
                            n_status = ial_pkg::ST_BADINDEX;
                        end else if ((w_idx + 1'b1) >= r_count) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            // Walk up from the index, moving each entry down one place.
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = ial_pkg::AW'(w_idx + 1'b1);
                            n_ptr           = w_idx;
                            n_state         = ial_pkg::S_DEL_SHIFT;
                        end
                    end
                    ial_pkg::MODE_READ: begin
                        if (w_idx >= r_count) begin
                            n_status = ial_pkg::ST_BADINDEX;
                        end else begin
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = r_item.index;
                            n_state         = ial_pkg::S_READ;
                        end
                    end
                    ial_pkg::MODE_FIND: begin
                        if (r_count != '0) begin
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = '0;
                            n_ptr           = '0;
                            n_state         = ial_pkg::S_FIND;
                        end
                    end
                    default: begin
                        // Unused codes do nothing and report ok.
                    end
                endcase
            end

            ial_pkg::S_INS_SHIFT: begin
                // The entry below r_ptr has arrived; store it one place higher.
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_ptr[ial_pkg::AW-1:0];
                o_ram_req.wdata = i_ram_rdata;
                if ((r_ptr - 1'b1) == w_idx) begin
                    n_state = ial_pkg::S_INS_PUT;
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = ial_pkg::AW'(r_ptr - ial_pkg::CW'(2));
                    n_ptr           = r_ptr - 1'b1;
                end
            end

            ial_pkg::S_INS_PUT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_item.index;
                o_ram_req.wdata = r_item.value;
                n_count         = r_count + 1'b1;
                n_state         = ial_pkg::S_RESULT;
            end

            ial_pkg::S_DEL_SHIFT: begin
                // The entry above r_ptr has arrived; store it one place lower.
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_ptr[ial_pkg::AW-1:0];
                o_ram_req.wdata = i_ram_rdata;
                if ((r_ptr + ial_pkg::CW'(2)) >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = ial_pkg::S_RESULT;
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = ial_pkg::AW'(r_ptr + ial_pkg::CW'(2));
                    n_ptr           = r_ptr + 1'b1;
                end
            end

            ial_pkg::S_FIND: begin
                // Compare one stored entry per cycle, stopping at the first match.
                if (i_ram_rdata == r_item.value) begin
                    n_found = 1'b1;
                    n_state = ial_pkg::S_RESULT;
                end else if ((r_ptr + 1'b1) >= r_count) begin
                    n_state = ial_pkg::S_RESULT;
                end else begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = ial_pkg::AW'(r_ptr + 1'b1);
                    n_ptr           = r_ptr + 1'b1;
                end
            end

            ial_pkg::S_READ: begin
                n_rd    = i_ram_rdata;
                n_state = ial_pkg::S_RESULT;
            end

            ial_pkg::S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ial_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ial_pkg::S_IDLE;
            end
        endcase
    end

    // Result fields; the count and flags reflect the state after the operation.
    always_comb begin
        o_res.status     = r_status;
        o_res.read_value = r_rd;
        o_res.found      = r_found;
        o_res.item_count = r_count;
        o_res.is_empty   = (r_count == '0);
        o_res.is_full    = w_full;
    end

endmodule

>>> sv/indexed_array_list.sv
// Indexed array list: a packed list of up to 64 signed words in one memory.
// Requests are handled one at a time: insert and delete walk the entries between the index
// and the top, find compares entries from the bottom until a match. Walks move one entry a cycle;
// the next request is taken only after the result has been handed to the output register.
// Synchronous active-low reset empties the list and sets the capacity limit to 64.
module indexed_array_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value [31:0], index [37:32], zeros above
    input  logic [2:0]  s_axis_tuser,   // mode [2:0]
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status [1:0], read_value [33:2], found [34],
                                        // item_count [41:35], is_empty [42],
                                        // is_full [43], zeros above
    // Capacity limit write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    logic [ial_pkg::CW-1:0] r_cap;
    ial_pkg::t_result       r_out;
    logic                   r_out_valid;

    ial_pkg::t_item         w_item;
    ial_pkg::t_result       w_res;
    logic                   w_res_valid;
    logic                   w_res_ready;
    ial_pkg::t_ram_req      w_ram_req;
    logic [ial_pkg::DW-1:0] w_ram_rdata;

    // Capacity limit register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ial_pkg::CW'(ial_pkg::DEPTH);
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Unpack the request.
    always_comb begin
        w_item.mode  = s_axis_tuser;
        w_item.value = s_axis_tdata[31:0];
        w_item.index = s_axis_tdata[37:32];
    end

    ial_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .i_item       (w_item),
        .o_item_ready (s_axis_tready),
        .i_cap        (r_cap),
        .i_res_ready  (w_res_ready),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_ram_req    (w_ram_req),
        .i_ram_rdata  (w_ram_rdata)
    );

    ial_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    // Output register: frees the sequencer as soon as a result is handed over.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

    // The count in a result never exceeds the built depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.item_count <= ial_pkg::CW'(ial_pkg::DEPTH)))
        else $error("item count above depth");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_empty == (r_out.item_count == '0)))
        else $error("empty flag disagrees with count");

    // While idle with no request, the fill count does not move.
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && !s_axis_tvalid) |=> $stable(w_res.item_count))
        else $error("count changed while idle");

    // A result waits in the sequencer only while the output register is held.
    a_res_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res_ready) |-> (r_out_valid && !m_axis_tready))
        else $error("result stalled without back-pressure");

endmodule
